@@ rtl/core/wsts_pkg.sv @@
// shared types and constants of the work stealing task scheduler
package wsts_pkg;

   localparam int MaxThreads = 128;
   localparam int MaxWorkers = 16;
   localparam int SlotBits   = 7;
   localparam int WorkerBits = 4;
   localparam int CountBits  = 8;
   localparam int QueueAddrBits = WorkerBits + SlotBits;
   localparam logic [31:0] SeedBase = 32'h9E3779B9;

   typedef enum logic [2:0] {
      SLOT_FREE    = 3'd0,
      SLOT_READY   = 3'd1,
      SLOT_RUNNING = 3'd2,
      SLOT_BLOCKED = 3'd3,
      SLOT_DEAD    = 3'd4
   } slot_state_type;

   typedef enum logic [1:0] {
      FUNC_SPAWN    = 2'd0,
      FUNC_DISPATCH = 2'd1,
      FUNC_RETURN   = 2'd2,
      FUNC_WAKE     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OUT_YIELD  = 2'd0,
      OUT_BLOCK  = 2'd1,
      OUT_FINISH = 2'd2,
      OUT_BAD    = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NONE    = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]           func;
      logic [WorkerBits-1:0] worker;
      logic [SlotBits-1:0]   thread;
      logic [1:0]           outcome;
   } req_word_type;

   typedef struct packed {
      logic [SlotBits-1:0] slot;
      logic [1:0]          status;
      logic                was_stolen;
      logic                all_done;
      logic [31:0]         run_total;
      logic [31:0]         steal_total;
      logic [7:0]          live_total;
      logic [7:0]          blocked_total;
   } rsp_word_type;

   // one xorshift step of the victim seed
   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

@@ rtl/core/wsts_if.sv @@
// valid/ready channel carrying one word
interface wsts_req_if;
   logic                  valid;
   logic                  ready;
   wsts_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wsts_rsp_if;
   logic                  valid;
   logic                  ready;
   wsts_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/wsts_ram.sv @@
// generic single port ram with registered read
module wsts_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ rtl/core/work_stealing_task_scheduler.sv @@
// top level of the work stealing task scheduler
//
// One request word is taken at a time. req_ready stays low from the accepting
// edge until the response word has been taken, and req_ready rises in the
// cycle after that. After reset, req_ready also stays low while the slot state
// table is cleared one slot a cycle. Every word passes through a decode state.
// An ignored request has its response word valid in the next cycle. A return
// that blocks or finishes works the same way, and a yield first passes through
// a queue write state. A wake passes through a slot check state and, when the
// slot is blocked, a queue write state. A spawn scans the slot table one slot
// at a time, each slot through a read state and then a check state, and passes
// through a queue write state once a slot is found. A dispatch from the
// worker's own queue passes through a ram read state and a ram data state
// before the response word. When the worker's own queue is empty and at least
// two workers are active, up to twice the worker count victim picks follow.
// Each pick is one xorshift step, a shift and subtract reduction modulo the
// worker count, and one victim check. Queue entries live in one single port
// ram of 2048 entries shared by all workers. The slot state table is a 128
// entry single port ram with registered read.
module work_stealing_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   wsts_req_if.sink          req,
   wsts_rsp_if.source        rsp
);

   localparam int SB = wsts_pkg::SlotBits;
   localparam int WB = wsts_pkg::WorkerBits;

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_DECODE = 13'b0000000000100,
      ST_SCAN   = 13'b0000000001000,
      ST_SCHK   = 13'b0000000010000,
      ST_WCHK   = 13'b0000000100000,
      ST_QWRITE = 13'b0000001000000,
      ST_QREAD  = 13'b0000010000000,
      ST_QDATA  = 13'b0000100000000,
      ST_PICK   = 13'b0001000000000,
      ST_MOD    = 13'b0010000000000,
      ST_VICTIM = 13'b0100000000000,
      ST_RESP   = 13'b1000000000000
   } state_type;

   state_type state_ff;

   // configuration
   logic [4:0] wcount_ff;
   logic [4:0] active_n;
   always_comb begin
      if (wcount_ff == 5'd0) active_n = 5'd1;
      else if (wcount_ff > 5'(wsts_pkg::MaxWorkers)) active_n = 5'(wsts_pkg::MaxWorkers);
      else active_n = wcount_ff;
   end

   // per worker state in flip-flops
   logic [SB-1:0] qhead_ff [wsts_pkg::MaxWorkers];
   logic [7:0]    qfill_ff [wsts_pkg::MaxWorkers];
   logic          rvalid_ff [wsts_pkg::MaxWorkers];
   logic [SB-1:0] rslot_ff [wsts_pkg::MaxWorkers];
   logic [31:0]   seed_ff [wsts_pkg::MaxWorkers];
   logic [31:0]   runs_ff [wsts_pkg::MaxWorkers];
   logic [31:0]   steals_ff [wsts_pkg::MaxWorkers];
   logic [7:0]    live_ff, blocked_ff;

   // request under work
   wsts_pkg::req_word_type cur_ff;
   logic [SB-1:0]  idx_ff;        // clear / scan index, slot to queue
   logic [WB-1:0]  qw_ff;         // queue owner being accessed
   logic [SB-1:0]  qpos_ff;       // position within that queue
   logic           stolen_ff;
   logic [5:0]     tries_ff;      // victim picks left
   logic [31:0]    rem_ff;        // remainder under reduction
   logic [4:0]     shift_ff;      // mod loop bit position
   logic [1:0]     status_ff;
   logic [SB-1:0]  slot_ff;
   logic           qwr_en;
   logic [SB-1:0]  qwr_data;
   logic [SB-1:0]  qrd_data;

   // slot state table port
   logic                     sram_wr_en;
   logic [SB-1:0]            sram_addr;
   wsts_pkg::slot_state_type sram_wr_data;
   logic [2:0]               sram_rd_data;

   wsts_ram #(.Width(SB), .Depth(wsts_pkg::MaxWorkers * wsts_pkg::MaxThreads)) u_queue (
      .clock   (clock),
      .wr_en   (qwr_en),
      .addr    ({qw_ff, qpos_ff}),
      .wr_data (qwr_data),
      .rd_data (qrd_data)
   );
   assign qwr_data = idx_ff;
   assign qwr_en = (state_ff == ST_QWRITE) && (qfill_ff[qw_ff] < 8'(wsts_pkg::MaxThreads));

   wsts_ram #(.Width(3), .Depth(wsts_pkg::MaxThreads)) u_slots (
      .clock   (clock),
      .wr_en   (sram_wr_en),
      .addr    (sram_addr),
      .wr_data (sram_wr_data),
      .rd_data (sram_rd_data)
   );

   logic [WB-1:0] w;
   assign w = cur_ff.worker;
   logic [35:0] n_shl;
   assign n_shl = {31'd0, active_n} << shift_ff;

   logic worker_on;
   logic ret_ok;
   logic scan_hit;
   logic wake_hit;
   assign worker_on = ({1'b0, w} < active_n);
   assign ret_ok    = worker_on && rvalid_ff[w] && (cur_ff.outcome != wsts_pkg::OUT_BAD);
   assign scan_hit  = (sram_rd_data == wsts_pkg::SLOT_FREE) ||
                      (sram_rd_data == wsts_pkg::SLOT_DEAD);
   assign wake_hit  = (sram_rd_data == wsts_pkg::SLOT_BLOCKED);

   // slot table access chosen by the sequencer, one address a cycle
   always_comb begin
      sram_wr_en   = 1'b0;
      sram_addr    = idx_ff;
      sram_wr_data = wsts_pkg::SLOT_FREE;
      case (state_ff)
         ST_CLEAR: sram_wr_en = 1'b1;
         ST_DECODE: begin
            if (cur_ff.func == wsts_pkg::FUNC_RETURN) begin
               sram_addr = rslot_ff[w];
               if (ret_ok) begin
                  sram_wr_en = 1'b1;
                  case (cur_ff.outcome)
                     wsts_pkg::OUT_YIELD: sram_wr_data = wsts_pkg::SLOT_READY;
                     wsts_pkg::OUT_BLOCK: sram_wr_data = wsts_pkg::SLOT_BLOCKED;
                     default:             sram_wr_data = wsts_pkg::SLOT_DEAD;
                  endcase
               end
            end else begin
               // read ahead for wake
               sram_addr = cur_ff.thread;
            end
         end
         ST_SCHK: begin
            if (scan_hit) begin
               sram_wr_en   = 1'b1;
               sram_wr_data = wsts_pkg::SLOT_READY;
            end
         end
         ST_WCHK: begin
            sram_addr = cur_ff.thread;
            if (wake_hit) begin
               sram_wr_en   = 1'b1;
               sram_wr_data = wsts_pkg::SLOT_READY;
            end
         end
         ST_QDATA: begin
            sram_addr    = qrd_data;
            sram_wr_en   = 1'b1;
            sram_wr_data = wsts_pkg::SLOT_RUNNING;
         end
         default: ;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RESP);

   always_comb begin
      rsp.data.slot          = slot_ff;
      rsp.data.status        = status_ff;
      rsp.data.was_stolen    = stolen_ff;
      rsp.data.all_done      = (live_ff == 8'd0);
      rsp.data.run_total     = runs_ff[w];
      rsp.data.steal_total   = steals_ff[w];
      rsp.data.live_total    = live_ff;
      rsp.data.blocked_total = blocked_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         idx_ff     <= '0;
         wcount_ff  <= 5'd1;
         live_ff    <= '0;
         blocked_ff <= '0;
         for (int i = 0; i < wsts_pkg::MaxWorkers; i++) begin
            qhead_ff[i]  <= '0;
            qfill_ff[i]  <= '0;
            rvalid_ff[i] <= 1'b0;
            rslot_ff[i]  <= '0;
            seed_ff[i]   <= wsts_pkg::SeedBase ^ 32'(i + 1);
            runs_ff[i]   <= '0;
            steals_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) wcount_ff <= csr_wr_data;
         case (state_ff)
            ST_CLEAR: begin
               // one slot a cycle back to free
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SB'(wsts_pkg::MaxThreads - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req.valid) begin
                  cur_ff    <= req.data;
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               stolen_ff <= 1'b0;
               qw_ff     <= w;
               if (!worker_on) begin
                  status_ff <= wsts_pkg::STATUS_IGNORED;
                  slot_ff   <= '0;
                  state_ff  <= ST_RESP;
               end else begin
                  case (cur_ff.func)
                     wsts_pkg::FUNC_SPAWN: begin
                        status_ff <= wsts_pkg::STATUS_NONE;
                        slot_ff   <= '0;
                        idx_ff    <= '0;
                        if (qfill_ff[w] < 8'(wsts_pkg::MaxThreads)) state_ff <= ST_SCAN;
                        else state_ff <= ST_RESP;
                     end
                     wsts_pkg::FUNC_DISPATCH: begin
                        slot_ff <= '0;
                        if (rvalid_ff[w]) begin
                           status_ff <= wsts_pkg::STATUS_IGNORED;
                           state_ff  <= ST_RESP;
                        end else if (qfill_ff[w] != 8'd0) begin
                           status_ff   <= wsts_pkg::STATUS_NONE;
                           qpos_ff     <= qhead_ff[w];
                           qhead_ff[w] <= qhead_ff[w] + 1'b1;
                           qfill_ff[w] <= qfill_ff[w] - 8'd1;
                           state_ff    <= ST_QREAD;
                        end else if (active_n >= 5'd2) begin
                           status_ff <= wsts_pkg::STATUS_NONE;
                           tries_ff  <= {active_n, 1'b0};
                           state_ff  <= ST_PICK;
                        end else begin
                           status_ff <= wsts_pkg::STATUS_NONE;
                           state_ff  <= ST_RESP;
                        end
                     end
                     wsts_pkg::FUNC_RETURN: begin
                        if (ret_ok) begin
                           rvalid_ff[w] <= 1'b0;
                           slot_ff   <= rslot_ff[w];
                           status_ff <= wsts_pkg::STATUS_OK;
                           case (cur_ff.outcome)
                              wsts_pkg::OUT_YIELD: begin
                                 idx_ff   <= rslot_ff[w];
                                 qpos_ff  <= qhead_ff[w] + qfill_ff[w][SB-1:0];
                                 state_ff <= ST_QWRITE;
                              end
                              wsts_pkg::OUT_BLOCK: begin
                                 blocked_ff <= blocked_ff + 8'd1;
                                 state_ff   <= ST_RESP;
                              end
                              default: begin
                                 if (live_ff != 8'd0) live_ff <= live_ff - 8'd1;
                                 state_ff <= ST_RESP;
                              end
                           endcase
                        end else begin
                           status_ff <= wsts_pkg::STATUS_IGNORED;
                           slot_ff   <= '0;
                           state_ff  <= ST_RESP;
                        end
                     end
                     default: begin
                        // wake: slot state read in flight
                        status_ff <= wsts_pkg::STATUS_IGNORED;
                        slot_ff   <= '0;
                        idx_ff    <= cur_ff.thread;
                        state_ff  <= ST_WCHK;
                     end
                  endcase
               end
            end
            ST_SCAN: state_ff <= ST_SCHK;   // slot state read in flight
            ST_SCHK: begin
               // lowest free or dead wins
               if (scan_hit) begin
                  live_ff   <= live_ff + 8'd1;
                  slot_ff   <= idx_ff;
                  status_ff <= wsts_pkg::STATUS_OK;
                  qpos_ff   <= qhead_ff[w] + qfill_ff[w][SB-1:0];
                  state_ff  <= ST_QWRITE;
               end else if (idx_ff == SB'(wsts_pkg::MaxThreads - 1)) begin
                  state_ff <= ST_RESP;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_WCHK: begin
               if (wake_hit) begin
                  if (blocked_ff != 8'd0) blocked_ff <= blocked_ff - 8'd1;
                  slot_ff   <= cur_ff.thread;
                  status_ff <= wsts_pkg::STATUS_OK;
                  qpos_ff   <= qhead_ff[w] + qfill_ff[w][SB-1:0];
                  state_ff  <= ST_QWRITE;
               end else begin
                  state_ff <= ST_RESP;
               end
            end
            ST_QWRITE: begin
               if (qwr_en) qfill_ff[qw_ff] <= qfill_ff[qw_ff] + 8'd1;
               state_ff <= ST_RESP;
            end
            ST_QREAD: state_ff <= ST_QDATA;   // ram read in flight
            ST_QDATA: begin
               runs_ff[w]   <= runs_ff[w] + 32'd1;
               rvalid_ff[w] <= 1'b1;
               rslot_ff[w]  <= qrd_data;
               slot_ff      <= qrd_data;
               status_ff    <= wsts_pkg::STATUS_OK;
               state_ff     <= ST_RESP;
            end
            ST_PICK: begin
               if (tries_ff == 6'd0) begin
                  state_ff <= ST_RESP;
               end else begin
                  tries_ff   <= tries_ff - 6'd1;
                  seed_ff[w] <= wsts_pkg::xorshift(seed_ff[w]);
                  rem_ff     <= wsts_pkg::xorshift(seed_ff[w]);
                  shift_ff   <= 5'd31;
                  state_ff   <= ST_MOD;
               end
            end
            ST_MOD: begin
               // restoring reduction: one shifted subtract a cycle
               if ({4'd0, rem_ff} >= n_shl) rem_ff <= rem_ff - n_shl[31:0];
               if (shift_ff == 5'd0) state_ff <= ST_VICTIM;
               else shift_ff <= shift_ff - 5'd1;
            end
            ST_VICTIM: begin
               qw_ff <= rem_ff[WB-1:0];
               if (rem_ff[WB-1:0] != w && qfill_ff[rem_ff[WB-1:0]] != 8'd0) begin
                  qfill_ff[rem_ff[WB-1:0]] <= qfill_ff[rem_ff[WB-1:0]] - 8'd1;
                  qpos_ff <= qhead_ff[rem_ff[WB-1:0]] +
                             SB'(qfill_ff[rem_ff[WB-1:0]] - 8'd1);
                  stolen_ff     <= 1'b1;
                  steals_ff[w]  <= steals_ff[w] + 32'd1;
                  state_ff      <= ST_QREAD;
               end else begin
                  state_ff <= ST_PICK;
               end
            end
            ST_RESP: begin
               if (rsp.ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // sequencer sanity
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("request taken with response pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VICTIM) |-> ({1'b0, rem_ff[WB-1:0]} < active_n && rem_ff[31:WB] == '0))
      else $error("victim out of range");

endmodule

@@ tb/sv/wsts_checker.sv @@
// checker for the work stealing task scheduler: predicts response words and compares them
`timescale 1ns / 1ps
module wsts_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [4:0]             csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  wsts_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  wsts_pkg::rsp_word_type rsp_data,
   output int                     fail_count,
   output int                     pending
);

   logic [4:0]       workers_reg;
   wsts_pkg::slot_state_type slot_tab [wsts_pkg::MaxThreads];
   logic [wsts_pkg::SlotBits-1:0] ring [wsts_pkg::MaxWorkers][wsts_pkg::MaxThreads];
   logic [wsts_pkg::SlotBits-1:0] head [wsts_pkg::MaxWorkers];
   logic [7:0]       fill [wsts_pkg::MaxWorkers];
   logic             busy [wsts_pkg::MaxWorkers];
   logic [wsts_pkg::SlotBits-1:0] current [wsts_pkg::MaxWorkers];
   logic [31:0]      seed [wsts_pkg::MaxWorkers];
   logic [31:0]      runs [wsts_pkg::MaxWorkers];
   logic [31:0]      steals [wsts_pkg::MaxWorkers];
   logic [7:0]       live;
   logic [7:0]       parked;
   wsts_pkg::rsp_word_type expected_words [$];

   function automatic int active_n();
      if (workers_reg < 5'd1) return 1;
      if (workers_reg > 5'(wsts_pkg::MaxWorkers)) return wsts_pkg::MaxWorkers;
      return int'(workers_reg);
   endfunction

   task automatic push_tail(input int w, input logic [wsts_pkg::SlotBits-1:0] s);
      if (fill[w] < wsts_pkg::MaxThreads) begin
         ring[w][(head[w] + fill[w]) % wsts_pkg::MaxThreads] = s;
         fill[w]++;
      end
   endtask

   task automatic schedule(input wsts_pkg::req_word_type r,
                           output wsts_pkg::rsp_word_type e);
      int n, w, v, t, i;
      logic got;
      logic [wsts_pkg::SlotBits-1:0] s;
      logic [31:0] x;
      n = active_n();
      w = int'(r.worker);
      got = 1'b0;
      s = '0;
      e = '0;
      e.status = wsts_pkg::STATUS_IGNORED;
      if (w < n) begin
         case (wsts_pkg::func_type'(r.func))
            wsts_pkg::FUNC_SPAWN: begin
               e.status = wsts_pkg::STATUS_NONE;
               if (fill[w] < wsts_pkg::MaxThreads) begin
                  for (i = 0; i < wsts_pkg::MaxThreads; i++) begin
                     if (slot_tab[i] == wsts_pkg::SLOT_FREE ||
                         slot_tab[i] == wsts_pkg::SLOT_DEAD) begin
                        slot_tab[i] = wsts_pkg::SLOT_READY;
                        live++;
                        push_tail(w, i[wsts_pkg::SlotBits-1:0]);
                        e.slot = i[wsts_pkg::SlotBits-1:0];
                        e.status = wsts_pkg::STATUS_OK;
                        break;
                     end
                  end
               end
            end
            wsts_pkg::FUNC_DISPATCH: begin
               if (!busy[w]) begin
                  if (fill[w] > 0) begin
                     s = ring[w][head[w]];
                     head[w] = head[w] + 1'b1;
                     fill[w]--;
                     got = 1'b1;
                  end else if (n >= 2) begin
                     // victim walk, own index skipped but still costs a pick
                     for (t = 0; t < 2 * n; t++) begin
                        x = seed[w];
                        x = x ^ (x << 13);
                        x = x ^ (x >> 17);
                        x = x ^ (x << 5);
                        seed[w] = x;
                        v = int'(x % 32'(n));
                        if (v == w) continue;
                        if (fill[v] > 0) begin
                           fill[v]--;
                           s = ring[v][(head[v] + fill[v]) % wsts_pkg::MaxThreads];
                           got = 1'b1;
                           e.was_stolen = 1'b1;
                           steals[w]++;
                           break;
                        end
                     end
                  end
                  if (got) begin
                     runs[w]++;
                     slot_tab[s] = wsts_pkg::SLOT_RUNNING;
                     busy[w] = 1'b1;
                     current[w] = s;
                     e.slot = s;
                     e.status = wsts_pkg::STATUS_OK;
                  end else begin
                     e.status = wsts_pkg::STATUS_NONE;
                  end
               end
            end
            wsts_pkg::FUNC_RETURN: begin
               if (busy[w] && wsts_pkg::outcome_type'(r.outcome) != wsts_pkg::OUT_BAD) begin
                  s = current[w];
                  busy[w] = 1'b0;
                  case (wsts_pkg::outcome_type'(r.outcome))
                     wsts_pkg::OUT_YIELD: begin
                        slot_tab[s] = wsts_pkg::SLOT_READY;
                        push_tail(w, s);
                     end
                     wsts_pkg::OUT_BLOCK: begin
                        slot_tab[s] = wsts_pkg::SLOT_BLOCKED;
                        parked++;
                     end
                     default: begin
                        slot_tab[s] = wsts_pkg::SLOT_DEAD;
                        if (live > 0) live--;
                     end
                  endcase
                  e.slot = s;
                  e.status = wsts_pkg::STATUS_OK;
               end
            end
            default: begin
               if (slot_tab[r.thread] == wsts_pkg::SLOT_BLOCKED) begin
                  slot_tab[r.thread] = wsts_pkg::SLOT_READY;
                  if (parked > 0) parked--;
                  push_tail(w, r.thread);
                  e.slot = r.thread;
                  e.status = wsts_pkg::STATUS_OK;
               end
            end
         endcase
      end
      e.all_done = (live == 8'd0);
      e.run_total = runs[w];
      e.steal_total = steals[w];
      e.live_total = live;
      e.blocked_total = parked;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending = expected_words.size();

   always @(posedge clock) begin
      wsts_pkg::rsp_word_type e, a;
      if (reset) begin
         workers_reg = 5'd1;
         live = '0;
         parked = '0;
         expected_words.delete();
         for (int i = 0; i < wsts_pkg::MaxThreads; i++) slot_tab[i] = wsts_pkg::SLOT_FREE;
         for (int w = 0; w < wsts_pkg::MaxWorkers; w++) begin
            head[w] = '0;
            fill[w] = '0;
            busy[w] = 1'b0;
            current[w] = '0;
            seed[w] = wsts_pkg::SeedBase ^ 32'(w + 1);
            runs[w] = '0;
            steals[w] = '0;
         end
      end else begin
         if (csr_wr_en) workers_reg = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            a = rsp_data;
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               check_field("slot", 32'(e.slot), 32'(a.slot));
               check_field("status", 32'(e.status), 32'(a.status));
               check_field("was_stolen", 32'(e.was_stolen), 32'(a.was_stolen));
               check_field("all_done", 32'(e.all_done), 32'(a.all_done));
               check_field("run_total", e.run_total, a.run_total);
               check_field("steal_total", e.steal_total, a.steal_total);
               check_field("live_total", 32'(e.live_total), 32'(a.live_total));
               check_field("blocked_total", 32'(e.blocked_total), 32'(a.blocked_total));
            end
         end
         if (req_valid && req_ready) begin
            schedule(req_data, e);
            expected_words.push_back(e);
         end
      end
   end

endmodule

@@ tb/sv/tb_work_stealing_task_scheduler.sv @@
// top of the work stealing task scheduler testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_work_stealing_task_scheduler;

   localparam int CycleLimit = 10000000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [4:0] csr_wr_data;
   int   fail_count;
   int   pending;
   int   cycles;
   logic long_hold;
   int   active_now;
   logic [wsts_pkg::SlotBits-1:0] recent_slots [$];

   wsts_req_if req ();
   wsts_rsp_if rsp ();

   work_stealing_task_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req.sink),
      .rsp         (rsp.source)
   );

   wsts_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_data    (req.data),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_data    (rsp.data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on total run length
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("tb_work_stealing_task_scheduler: FAIL");
            $finish;
         end
      end
   end

   // remember slots from good responses so wakes often hit a blocked one
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready && rsp.data.status == wsts_pkg::STATUS_OK) begin
         recent_slots.push_back(rsp.data.slot);
         if (recent_slots.size() > 16) void'(recent_slots.pop_front());
      end
   end

   // response side: random stalls, mostly short, some long, plus one forced long hold
   initial begin
      int hold;
      int pick;
      hold = 0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            hold--;
         end else if (long_hold) begin
            long_hold = 1'b0;
            hold = 600;
            rsp.ready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) rsp.ready <= 1'b1;
            else if (pick < 95) begin
               hold = $urandom_range(0, 3);
               rsp.ready <= 1'b0;
            end else begin
               hold = $urandom_range(20, 120);
               rsp.ready <= 1'b0;
            end
         end
      end
   end

   // idle gap before a word: mostly none or short, a few long
   function automatic int gap_len(input logic quiet);
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // offer one word; valid stays high across back-to-back words
   task automatic send_word(input wsts_pkg::func_type f, input int w, input int th,
                            input int oc, input logic quiet);
      int gap;
      wsts_pkg::req_word_type word;
      gap = gap_len(quiet);
      word.func = f;
      word.worker = wsts_pkg::WorkerBits'(w);
      word.thread = wsts_pkg::SlotBits'(th);
      word.outcome = 2'(oc);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.data <= word;
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // wait for the block to drain, then program the worker count
   task automatic set_workers(input logic [4:0] value);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value < 5'd1) active_now = 1;
      else if (value > 5'(wsts_pkg::MaxWorkers)) active_now = wsts_pkg::MaxWorkers;
      else active_now = int'(value);
   endtask

   // one random word; spawn_bias raises the share of spawns to fill the table
   task automatic random_word(input int spawn_bias, input logic quiet);
      int p, w, th, oc;
      wsts_pkg::func_type f;
      p = $urandom_range(0, 99);
      if (p < spawn_bias) f = wsts_pkg::FUNC_SPAWN;
      else if (p < spawn_bias + (100 - spawn_bias) * 4 / 10) f = wsts_pkg::FUNC_DISPATCH;
      else if (p < spawn_bias + (100 - spawn_bias) * 8 / 10) f = wsts_pkg::FUNC_RETURN;
      else f = wsts_pkg::FUNC_WAKE;
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 15);
      else w = $urandom_range(0, active_now - 1);
      p = $urandom_range(0, 99);
      if (p < 45) oc = int'(wsts_pkg::OUT_YIELD);
      else if (p < 70) oc = int'(wsts_pkg::OUT_BLOCK);
      else if (p < 95) oc = int'(wsts_pkg::OUT_FINISH);
      else oc = int'(wsts_pkg::OUT_BAD);
      if (f == wsts_pkg::FUNC_WAKE && recent_slots.size() > 0 && $urandom_range(0, 9) < 7)
         th = int'(recent_slots[$urandom_range(0, recent_slots.size() - 1)]);
      else th = $urandom_range(0, 127);
      send_word(f, w, th, oc, quiet);
   endtask

   initial begin
      logic [4:0] counts [8];
      counts = '{5'd16, 5'd0, 5'd2, 5'd31, 5'd1, 5'd5, 5'd16, 5'd9};
      long_hold = 1'b0;
      active_now = 1;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset worker count of one
      send_word(wsts_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);   // empty queue, no steal
      send_word(wsts_pkg::FUNC_RETURN, 0, 0, 0, 1'b0);     // nothing running
      send_word(wsts_pkg::FUNC_SPAWN, 0, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_SPAWN, 15, 127, 3, 1'b0);   // inactive worker
      send_word(wsts_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);   // dispatch while running
      send_word(wsts_pkg::FUNC_RETURN, 0, 0, int'(wsts_pkg::OUT_BAD), 1'b0);    // bad outcome
      send_word(wsts_pkg::FUNC_RETURN, 0, 0, int'(wsts_pkg::OUT_YIELD), 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_RETURN, 0, 0, int'(wsts_pkg::OUT_BLOCK), 1'b0);
      send_word(wsts_pkg::FUNC_WAKE, 0, 127, 0, 1'b0);     // slot not blocked
      send_word(wsts_pkg::FUNC_WAKE, 0, 0, 0, 1'b0);       // the blocked one
      send_word(wsts_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_RETURN, 0, 0, int'(wsts_pkg::OUT_FINISH), 1'b0); // live to zero
      send_word(wsts_pkg::FUNC_SPAWN, 0, 0, 0, 1'b0);      // reuses the dead slot

      // sixteen workers: fill worker 3 and steal from it
      set_workers(5'd16);
      send_word(wsts_pkg::FUNC_SPAWN, 3, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_SPAWN, 3, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_SPAWN, 15, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 7, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 12, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 15, 0, 0, 1'b0);
      send_word(wsts_pkg::FUNC_DISPATCH, 1, 0, 0, 1'b0);

      // random phases over several worker counts
      for (int ph = 0; ph < 8; ph++) begin
         set_workers(counts[ph]);
         for (int k = 0; k < 120; k++) begin
            if (ph == 2 && k == 10) long_hold = 1'b1;   // response held back long, so the block stalls its input
            if (ph == 6 && k == 60) begin
               // sender pauses until everything has drained
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            random_word((ph == 3) ? 75 : 30, (ph == 5));
         end
      end
      set_workers(5'($urandom_range(0, 31)));
      for (int k = 0; k < 40; k++) random_word(30, 1'b0);

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_work_stealing_task_scheduler: PASS");
      end else begin
         $display("tb_work_stealing_task_scheduler: FAIL");
      end
      $finish;
   end

endmodule
